// ===== rtl/dts_pkg.sv =====
// Shared types and constants for the deadline timer scheduler.
// No dependencies; every other file in rtl/ imports this package.
package dts_pkg;

    // Table size default and per-tick firing limit
    localparam int DEFAULT_NUM_TIMERS = 16;
    localparam int FIRE_LIMIT         = 16;
    localparam int FIRE_W             = $clog2(FIRE_LIMIT);

    // Field widths
    localparam int TIME_W = 32;
    localparam int OP_W   = 2;
    localparam int ID_W   = 4;
    localparam int DUR_W  = 16;
    localparam int REP_W  = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

    // One timer table entry
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [DUR_W-1:0]  period;
        logic [REP_W-1:0]  repeats_left;
    } entry_t;

    // Result of the shared deadline comparator
    typedef struct packed {
        logic              due;
        logic              better;
        logic [TIME_W-1:0] key;
    } cmp_res_t;

endpackage

// ===== rtl/dts_if.sv =====
// Handshake channel interfaces for the deadline timer scheduler.
// Depends on dts_pkg for the field widths.
interface dts_cmd_if import dts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   timer_id;
    logic [DUR_W-1:0]  duration;
    logic [REP_W-1:0]  repeats;

    modport source (output valid, operation, timer_id, duration, repeats, input ready);
    modport sink   (input valid, operation, timer_id, duration, repeats, output ready);
endinterface

interface dts_fire_if import dts_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] fired_id;
    logic            rearmed;
    logic            last;

    modport source (output valid, fired_id, rearmed, last, input ready);
    modport sink   (input valid, fired_id, rearmed, last, output ready);
endinterface

// ===== rtl/dts_mem.sv =====
// Timer entry memory: deadline, period and remaining repeats per timer.
// One write port, one registered read port. Depends on dts_pkg.
module dts_mem import dts_pkg::*; #(
    parameter int NUM_TIMERS = DEFAULT_NUM_TIMERS
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(NUM_TIMERS)-1:0] wr_addr,
    input  entry_t                        wr_data,
    input  logic [$clog2(NUM_TIMERS)-1:0] rd_addr,
    output entry_t                        rd_data
);

    entry_t mem_reg [NUM_TIMERS];
    entry_t rd_data_reg;

    // Write and registered read; contents are undefined until written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dts_cmp.sv =====
// Shared deadline comparator: due test and ordering against the best so far.
// Pure logic, used once per scanned entry. Depends on dts_pkg.
module dts_cmp import dts_pkg::*; (
    input  logic [TIME_W-1:0] now,
    input  logic [TIME_W-1:0] deadline,
    input  logic [TIME_W-1:0] best_key,
    input  logic              have_best,
    output cmp_res_t          res
);

    logic [TIME_W-1:0] diff;

    // Wrapping difference; due when zero or negative
    assign diff = deadline - now;

    always_comb
    begin
        res.due    = (diff == '0) || diff[TIME_W-1];
        // Signed order mapped onto unsigned order
        res.key    = {~diff[TIME_W-1], diff[TIME_W-2:0]};
        res.better = !have_best || (res.key < best_key);
    end

endmodule

// ===== rtl/deadline_timer_scheduler.sv =====
// Deadline timer scheduler top level: sequencer, armed/done flags, time counter.
// Depends on dts_pkg, dts_if, dts_mem and dts_cmp.
//
// A table of NUM_TIMERS timers. Add, remove and clear are carried out in the idle state.
// A tick bumps the time counter and then scans the table one entry per cycle
// through the single read port of the entry memory and one shared comparator,
// picking the due timer with the earliest deadline (lower number on a tie).
// Each firing costs one full scan plus a fetch; the fetch waits while the
// result side stalls. A tick that fires nothing returns to idle after its
// scan. No more commands are taken until the tick is finished. At most 16
// timers fire per tick; others that are due stay armed for a later tick.
module deadline_timer_scheduler import dts_pkg::*; #(
    parameter int NUM_TIMERS = DEFAULT_NUM_TIMERS
) (
    input  logic              clk,
    input  logic              rst_n,
    dts_cmd_if.sink           cmd,
    dts_fire_if.source        fire
);

    localparam int IDX_W = $clog2(NUM_TIMERS);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FETCH  = 3'd4;

    logic [2:0]            state_reg;
    logic [TIME_W-1:0]     cur_time_reg;
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [NUM_TIMERS-1:0] done_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  rd_v_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      best_reg;
    logic [TIME_W-1:0]     best_key_reg;
    logic                  have_best_reg;
    logic                  found_two_reg;
    logic [FIRE_W-1:0]     fire_cnt_reg;
    logic                  fire_valid_reg;
    logic [ID_W-1:0]       fired_id_reg;
    logic                  rearmed_reg;
    logic                  last_reg;

    logic                  cmd_acc;
    logic                  id_ok;
    logic [IDX_W-1:0]      cmd_idx;
    logic                  out_free;
    logic                  fire_now;
    logic                  rearm;
    logic                  is_last;
    logic                  eligible;
    logic [DUR_W-1:0]      add_dur;
    logic [TIME_W-1:0]     deadline_next;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;
    logic [IDX_W-1:0]      rd_addr;
    entry_t                rd_data;
    cmp_res_t              cmp_res;

    // Handshake and command decode
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign id_ok     = int'(cmd.timer_id) < NUM_TIMERS;
    assign cmd_idx   = IDX_W'(cmd.timer_id);

    // Result beat goes out when the output register is free
    assign out_free = !fire_valid_reg || fire.ready;
    assign fire_now = (state_reg == S_FETCH) && out_free;
    assign rearm    = (rd_data.repeats_left != '0);
    assign is_last  = !found_two_reg || (fire_cnt_reg == FIRE_W'(FIRE_LIMIT - 1));

    // One adder serves both add and re-arm
    assign add_dur       = (state_reg == S_IDLE) ? cmd.duration : rd_data.period;
    assign deadline_next = cur_time_reg + TIME_W'(add_dur);

    // Entry memory ports
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            wr_en                = cmd_acc && (cmd.operation == OP_ADD) && id_ok;
            wr_addr              = cmd_idx;
            wr_data.deadline     = deadline_next;
            wr_data.period       = cmd.duration;
            wr_data.repeats_left = cmd.repeats;
        end
        else
        begin
            wr_en                = fire_now && rearm;
            wr_addr              = best_reg;
            wr_data.deadline     = deadline_next;
            wr_data.period       = rd_data.period;
            wr_data.repeats_left = rd_data.repeats_left - REP_W'(1);
        end
    end

    assign rd_addr = ((state_reg == S_DECIDE) || (state_reg == S_FETCH)) ? best_reg : idx_reg;

    dts_mem #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dts_cmp u_cmp (
        .now       (cur_time_reg),
        .deadline  (rd_data.deadline),
        .best_key  (best_key_reg),
        .have_best (have_best_reg),
        .res       (cmp_res)
    );

    // Scanned entry takes part only if armed, not yet fired and due
    assign eligible = rd_v_reg && armed_reg[rd_idx_reg] && !done_reg[rd_idx_reg] && cmp_res.due;

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_time_reg   <= '0;
            armed_reg      <= '0;
            done_reg       <= '0;
            idx_reg        <= '0;
            rd_v_reg       <= 1'b0;
            rd_idx_reg     <= '0;
            best_reg       <= '0;
            best_key_reg   <= '0;
            have_best_reg  <= 1'b0;
            found_two_reg  <= 1'b0;
            fire_cnt_reg   <= '0;
            fire_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= (state_reg == S_SCAN);
            rd_idx_reg <= idx_reg;

            // Running minimum over the scan
            if (eligible)
            begin
                if (cmp_res.better)
                begin
                    best_reg     <= rd_idx_reg;
                    best_key_reg <= cmp_res.key;
                end
                if (have_best_reg)
                begin
                    found_two_reg <= 1'b1;
                end
                have_best_reg <= 1'b1;
            end

            // Output register: loaded on a firing, emptied when taken
            if (fire_now)
            begin
                fire_valid_reg <= 1'b1;
            end
            else if (fire_valid_reg && fire.ready)
            begin
                fire_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_acc)
                    begin
                        unique case (cmd.operation)
                            OP_ADD:
                            begin
                                if (id_ok)
                                begin
                                    armed_reg[cmd_idx] <= 1'b1;
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (id_ok)
                                begin
                                    armed_reg[cmd_idx] <= 1'b0;
                                end
                            end
                            OP_CLEAR:
                            begin
                                armed_reg <= '0;
                            end
                            OP_TICK:
                            begin
                                cur_time_reg  <= cur_time_reg + TIME_W'(1);
                                done_reg      <= '0;
                                fire_cnt_reg  <= '0;
                                idx_reg       <= '0;
                                have_best_reg <= 1'b0;
                                found_two_reg <= 1'b0;
                                state_reg     <= S_SCAN;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(NUM_TIMERS - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    state_reg <= have_best_reg ? S_FETCH : S_IDLE;
                end
                S_FETCH:
                begin
                    if (out_free)
                    begin
                        done_reg[best_reg] <= 1'b1;
                        if (!rearm)
                        begin
                            armed_reg[best_reg] <= 1'b0;
                        end
                        fire_cnt_reg <= fire_cnt_reg + FIRE_W'(1);
                        if (is_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg       <= '0;
                            have_best_reg <= 1'b0;
                            found_two_reg <= 1'b0;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire_now)
        begin
            fired_id_reg <= ID_W'(best_reg);
            rearmed_reg  <= rearm;
            last_reg     <= is_last;
        end
    end

    assign fire.valid    = fire_valid_reg;
    assign fire.fired_id = fired_id_reg;
    assign fire.rearmed  = rearmed_reg;
    assign fire.last     = last_reg;

`ifndef SYNTHESIS
    // A fetch only happens once the scan has found a candidate
    a_fetch_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> have_best_reg)
        else $error("fetch without a selected timer");

    // The selected timer is still armed when it fires
    a_best_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> armed_reg[best_reg])
        else $error("selected timer not armed");

    // A tick starts a fresh scan from entry zero
    a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && (cmd.operation == OP_TICK)) |=> (state_reg == S_SCAN) && (idx_reg == '0))
        else $error("tick did not start a scan");

    // The firing counter never wraps within a tick
    a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_now && !is_last) |=> (fire_cnt_reg != '0))
        else $error("firing counter wrapped");
`endif

endmodule

// ===== tb/sv/dts_firing_checker.sv =====
// Firing checker for the deadline timer scheduler testbench: watches both channels,
// keeps its own copy of the timer table and compares every firing beat with it.
// Depends on dts_pkg and the channel interfaces in dts_if.
module dts_firing_checker import dts_pkg::*; #(
    parameter int NUM_TIMERS = DEFAULT_NUM_TIMERS
) (
    input  logic clk,
    input  logic rst_n,
    dts_cmd_if   cmd,
    dts_fire_if  fire,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic [ID_W-1:0] fired_id;
        logic            rearmed;
        logic            last;
    } firing_t;

    localparam int OWED_W     = 6;
    localparam int OWED_DEPTH = 1 << OWED_W;

    // Timer table as the block should hold it
    logic [TIME_W-1:0] now_ticks;
    logic              armed     [NUM_TIMERS];
    logic [TIME_W-1:0] due_at    [NUM_TIMERS];
    logic [DUR_W-1:0]  period    [NUM_TIMERS];
    logic [REP_W-1:0]  reps_left [NUM_TIMERS];

    // Firings still owed by the block, oldest first, in a ring
    firing_t           owed_buf [OWED_DEPTH];
    logic [OWED_W-1:0] owed_rd;
    logic [OWED_W-1:0] owed_wr;
    int                owed_count;
    firing_t           oldest;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic owe_firing(input firing_t f);
        if (owed_count == OWED_DEPTH)
        begin
            report_mismatch("firing backlog overflow");
        end
        else
        begin
            owed_buf[owed_wr] = f;
            owed_wr = owed_wr + OWED_W'(1);
            owed_count++;
        end
    endtask

    task automatic take_oldest(output firing_t f);
        f = owed_buf[owed_rd];
        owed_rd = owed_rd + OWED_W'(1);
        owed_count--;
    endtask

    // Deadline reached when (deadline - now) as a signed value is <= 0
    function automatic logic reached(input logic [TIME_W-1:0] dl);
        logic [TIME_W-1:0] diff;
        diff = dl - now_ticks;
        return (diff == '0) || diff[TIME_W-1];
    endfunction

    // Advance time, then fire due timers in deadline order, lower number on a tie
    task automatic run_tick();
        logic              fired [NUM_TIMERS];
        firing_t           batch [FIRE_LIMIT];
        int                count;
        int                best;
        logic [TIME_W-1:0] key;
        logic [TIME_W-1:0] best_key;
        count = 0;
        best_key = '0;
        now_ticks = now_ticks + TIME_W'(1);
        for (int i = 0; i < NUM_TIMERS; i++)
            fired[i] = 1'b0;
        while (count < FIRE_LIMIT)
        begin
            best = -1;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (armed[i] && !fired[i] && reached(due_at[i]))
                begin
                    // signed difference mapped onto unsigned order
                    key = (due_at[i] - now_ticks) ^ {1'b1, {(TIME_W-1){1'b0}}};
                    if (best < 0 || key < best_key)
                    begin
                        best = i;
                        best_key = key;
                    end
                end
            end
            if (best < 0)
                break;
            fired[best] = 1'b1;
            batch[count].fired_id = best[ID_W-1:0];
            batch[count].last = 1'b0;
            if (reps_left[best] != '0)
            begin
                reps_left[best] = reps_left[best] - REP_W'(1);
                due_at[best] = now_ticks + TIME_W'(period[best]);
                batch[count].rearmed = 1'b1;
            end
            else
            begin
                armed[best] = 1'b0;
                batch[count].rearmed = 1'b0;
            end
            count++;
        end
        for (int n = 0; n < count; n++)
        begin
            if (n == count - 1)
                batch[n].last = 1'b1;
            owe_firing(batch[n]);
        end
    endtask

    task automatic apply_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                 input logic [DUR_W-1:0] dur, input logic [REP_W-1:0] rep);
        case (op)
            OP_ADD:
            begin
                // out-of-table numbers are ignored
                if (int'(id) < NUM_TIMERS)
                begin
                    armed[id] = 1'b1;
                    period[id] = dur;
                    reps_left[id] = rep;
                    due_at[id] = now_ticks + TIME_W'(dur);
                end
            end
            OP_REMOVE:
            begin
                if (int'(id) < NUM_TIMERS)
                    armed[id] = 1'b0;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                    armed[i] = 1'b0;
            end
            default:
            begin
                run_tick();
            end
        endcase
    endtask

    // Sample both channels at every edge; commands before firings
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ticks = '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                armed[i] = 1'b0;
                due_at[i] = '0;
                period[i] = '0;
                reps_left[i] = '0;
            end
            owed_rd = '0;
            owed_wr = '0;
            owed_count = 0;
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                apply_command(cmd.operation, cmd.timer_id, cmd.duration, cmd.repeats);
            if (fire.valid && fire.ready)
            begin
                if (owed_count == 0)
                begin
                    report_mismatch($sformatf("unexpected firing beat, timer %0d",
                                              fire.fired_id));
                end
                else
                begin
                    take_oldest(oldest);
                    if (fire.fired_id !== oldest.fired_id)
                        report_mismatch($sformatf("fired_id %0d, want %0d",
                                                  fire.fired_id, oldest.fired_id));
                    if (fire.rearmed !== oldest.rearmed)
                        report_mismatch($sformatf("timer %0d rearmed %0b, want %0b",
                                                  oldest.fired_id, fire.rearmed,
                                                  oldest.rearmed));
                    if (fire.last !== oldest.last)
                        report_mismatch($sformatf("timer %0d last %0b, want %0b",
                                                  oldest.fired_id, fire.last, oldest.last));
                end
            end
            pending <= owed_count;
        end
    end

endmodule

// ===== tb/sv/tb_deadline_timer_scheduler.sv =====
// Testbench top for the deadline timer scheduler: clock, reset, command stimulus,
// result-side back-pressure and the verdict.
// Depends on dts_pkg, dts_if, the RTL and dts_firing_checker.
module tb_deadline_timer_scheduler import dts_pkg::*; ();

    localparam int ITEM_TARGET   = 330;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_AT_BEAT  = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int PAUSE_AT_ITEM = 170;
    localparam int SETTLE_CYCLES = 2 * DEFAULT_NUM_TIMERS + 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   pending;
    int   sent;
    int   cycles;
    int   cmd_run;
    int   fire_run;

    dts_cmd_if  cmd_ch();
    dts_fire_if fire_ch();

    deadline_timer_scheduler uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .fire  (fire_ch)
    );

    dts_firing_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .fire       (fire_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    // Random gap before a beat, with occasional runs of back-to-back beats
    function automatic int draw_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // Mostly short periods so timers fire often; now and then any 16-bit value
    function automatic logic [DUR_W-1:0] pick_duration();
        if ($urandom_range(0, 7) == 0)
            return DUR_W'($urandom_range(0, 65535));
        return DUR_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [REP_W-1:0] pick_repeats();
        if ($urandom_range(0, 7) == 0)
            return REP_W'($urandom_range(0, 255));
        return REP_W'($urandom_range(0, 3));
    endfunction

    // One command beat, after a random gap
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [DUR_W-1:0] dur, input logic [REP_W-1:0] rep);
        int gap;
        gap = draw_gap(cmd_run);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.timer_id  <= id;
        cmd_ch.duration  <= dur;
        cmd_ch.repeats   <= rep;
        do @(posedge clk); while (!cmd_ch.ready);
        sent++;
    endtask

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d firings outstanding", cycles, pending);
        $display("[deadline_timer_scheduler] ERROR");
        $finish;
    end

    // Result side: random stalls, one long hold-off to back the block up
    initial
    begin
        int gap;
        int beats;
        beats = 0;
        fire_run = 0;
        fire_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (beats == HOLD_AT_BEAT)
                gap = HOLD_CYCLES;
            else
                gap = draw_gap(fire_run);
            if (gap > 0)
            begin
                fire_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            fire_ch.ready <= 1'b1;
            do @(posedge clk); while (!fire_ch.valid);
            beats++;
        end
    end

    // Command stimulus and verdict
    initial
    begin
        int              kind;
        int              n;
        logic [DUR_W-1:0] d;
        logic [REP_W-1:0] r;
        bit              paused;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.operation <= OP_TICK;
        cmd_ch.timer_id  <= '0;
        cmd_ch.duration  <= '0;
        cmd_ch.repeats   <= '0;
        sent = 0;
        cmd_run = 0;
        paused = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-ones fields, then disarm before it can fire
        send_cmd(OP_ADD, 4'd15, 16'hFFFF, 8'hFF);
        send_cmd(OP_REMOVE, 4'd15, '0, '0);
        // zero-duration one-shot fires on the very next tick
        send_cmd(OP_ADD, 4'd0, 16'd0, 8'd0);
        send_cmd(OP_TICK, '0, '0, '0);
        // equal deadlines go to the lower number; timer 3 re-arms once
        send_cmd(OP_ADD, 4'd5, 16'd2, 8'd0);
        send_cmd(OP_ADD, 4'd3, 16'd2, 8'd1);
        repeat (4) send_cmd(OP_TICK, '0, '0, '0);
        // zero period re-arm fires on each following tick, then stops
        send_cmd(OP_ADD, 4'd7, 16'd0, 8'd1);
        repeat (3) send_cmd(OP_TICK, '0, '0, '0);
        // re-adding an armed timer restarts it; clear disarms everything
        send_cmd(OP_ADD, 4'd1, 16'd1, 8'd0);
        send_cmd(OP_ADD, 4'd1, 16'd3, 8'd0);
        send_cmd(OP_ADD, 4'd2, 16'd1, 8'd0);
        send_cmd(OP_CLEAR, '0, '0, '0);
        send_cmd(OP_TICK, '0, '0, '0);

        // random part opens with a full table so every timer can fire on one tick
        kind = 1;
        while (sent < ITEM_TARGET)
        begin
            // once, let every owed firing drain before going on
            if (!paused && sent >= PAUSE_AT_ITEM)
            begin
                paused = 1'b1;
                cmd_ch.valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            case (kind)
                0:
                begin
                    // arm a few timers, then let time run
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_cmd(OP_ADD, ID_W'($urandom_range(0, 15)),
                                 pick_duration(), pick_repeats());
                    n = $urandom_range(1, 8);
                    repeat (n) send_cmd(OP_TICK, '0, '0, '0);
                end
                1:
                begin
                    // whole table with one shared short period
                    d = DUR_W'($urandom_range(0, 1));
                    for (int i = 0; i < 16; i++)
                    begin
                        r = REP_W'($urandom_range(0, 2));
                        send_cmd(OP_ADD, ID_W'(i), d, r);
                    end
                    n = $urandom_range(2, 5);
                    repeat (n) send_cmd(OP_TICK, '0, '0, '0);
                end
                default:
                begin
                    // noise: any operation with any field values
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_cmd(OP_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)),
                                 DUR_W'($urandom_range(0, 65535)),
                                 REP_W'($urandom_range(0, 255)));
                end
            endcase
            n = $urandom_range(0, 9);
            if (n <= 5)
                kind = 0;
            else if (n == 6)
                kind = 1;
            else
                kind = 2;
        end
        cmd_ch.valid <= 1'b0;

        // drain, then give a last empty scan time to finish
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[deadline_timer_scheduler] OK");
        else
            $display("[deadline_timer_scheduler] ERROR");
        $finish;
    end

endmodule

// ===== deadline_timer_scheduler.f =====
rtl/dts_pkg.sv
rtl/dts_if.sv
rtl/dts_mem.sv
rtl/dts_cmp.sv
rtl/deadline_timer_scheduler.sv
tb/sv/dts_firing_checker.sv
tb/sv/tb_deadline_timer_scheduler.sv
